// ===== design/sism_pkg.sv =====
// Package: shared types and codes for the sorted interval set merge block.
package sism_pkg;

  localparam int unsigned CpW     = 21;
  localparam int unsigned IndexW  = 5;
  localparam int unsigned TotalW  = 6;
  localparam int unsigned EntryW  = 2 * CpW;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_READ   = 2'd1,
    FUNC_CLEAR  = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_RANGE = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_FULLCHK,
    S_MERGE,
    S_RESP
  } state_e;

endpackage

// ===== design/sorted_interval_set_merge.sv =====
// Top level: sorted table of disjoint code-point ranges with merging insert.
// A read fetches the requested entry; clear and a rejected insert make no table
// pass; an insert makes one RAM read per stored entry and, when the table is
// full, first a read-only pass that checks for a merge (an insert with no merge
// partner is refused). One item is in work at a time; a finished result waits in
// the output register while the next item is taken.
// Reset empties the table at once.
module sorted_interval_set_merge import sism_pkg::*; #(
  parameter int unsigned MAX_RANGES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [20:0] range_low, [41:21] range_high, [46:42] entry_index, [47] zero
  input  logic [47:0] s_axis_tdata_i,
  // [1:0] func
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [20:0] entry_low, [41:21] entry_high, [47:42] range_total
  output logic [47:0] m_axis_tdata_o,
  // [1:0] status
  output logic [1:0]  m_axis_tuser_o
);

  localparam int unsigned AW = $clog2(MAX_RANGES);
  localparam int unsigned CW = $clog2(MAX_RANGES + 1);

  // Input fields.
  logic [CpW-1:0]    in_lo, in_hi;
  logic [IndexW-1:0] in_idx;
  func_e             in_func;
  logic              in_xfer;

  assign in_lo   = s_axis_tdata_i[CpW-1:0];
  assign in_hi   = s_axis_tdata_i[2*CpW-1:CpW];
  assign in_idx  = s_axis_tdata_i[2*CpW+IndexW-1:2*CpW];
  assign in_func = func_e'(s_axis_tuser_i);

  state_e state_q, state_d;
  logic [CW-1:0]  count_q, count_d;
  logic [CW-1:0]  i_q, i_d;          // next stored entry to consume
  logic [CW-1:0]  w_q, w_d;          // next entry to write back
  logic           rpend_q, rpend_d;  // new range not yet merged into stream
  logic           curv_q, curv_d;    // accumulated interval is valid
  logic           touch_q, touch_d;  // full-table pass found a merge partner
  logic           idx_ok_q, idx_ok_d;
  logic [CpW-1:0] cur_lo_q, cur_lo_d, cur_hi_q, cur_hi_d;
  logic [CpW-1:0] r_lo_q, r_lo_d, r_hi_q, r_hi_d;
  logic [CpW-1:0] res_lo_q, res_lo_d, res_hi_q, res_hi_d;
  status_e        res_st_q, res_st_d;
  logic           mval_q, mval_d;
  logic [47:0]    mdata_q, mdata_d;
  logic [1:0]     muser_q, muser_d;

  // Table RAM: entry = {high, low}.
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [EntryW-1:0] ram_wdata, ram_rdata;
  logic [CpW-1:0]    e_lo, e_hi;

  sism_ram #(
    .WIDTH (EntryW),
    .DEPTH (MAX_RANGES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign e_lo = ram_rdata[CpW-1:0];
  assign e_hi = ram_rdata[EntryW-1:CpW];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = mval_q;
  assign m_axis_tdata_o  = mdata_q;
  assign m_axis_tuser_o  = muser_q;

  // Shared decisions of the scan passes (RAM data holds entry i_q).
  logic           scan_end, take_r, joins, touches, out_free;
  logic [CpW-1:0] x_lo, x_hi;

  assign scan_end = (i_q == count_q);
  // Feed the new range into the sorted stream ahead of the first entry not below it.
  assign take_r   = rpend_q && (scan_end || (r_lo_q <= e_lo));
  assign x_lo     = take_r ? r_lo_q : e_lo;
  assign x_hi     = take_r ? r_hi_q : e_hi;
  // Overlapping or adjacent to the accumulated interval.
  assign joins    = curv_q && ({1'b0, x_lo} <= ({1'b0, cur_hi_q} + 22'd1));
  assign touches  = (({1'b0, e_hi} + 22'd1) >= {1'b0, r_lo_q}) &&
                    ({1'b0, e_lo} <= ({1'b0, r_hi_q} + 22'd1));
  assign out_free = !mval_q || m_axis_tready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_func == FUNC_READ) begin
            state_d = S_READ;
          end else if (in_func == FUNC_INSERT && in_lo <= in_hi) begin
            state_d = (32'(count_q) == MAX_RANGES) ? S_FULLCHK : S_MERGE;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_READ:    state_d = S_RESP;
      S_FULLCHK: begin
        if (scan_end) begin
          state_d = touch_q ? S_MERGE : S_RESP;
        end
      end
      S_MERGE: begin
        if (!rpend_q && scan_end) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and RAM control.
  always_comb begin
    count_d   = count_q;
    i_d       = i_q;
    w_d       = w_q;
    rpend_d   = rpend_q;
    curv_d    = curv_q;
    touch_d   = touch_q;
    idx_ok_d  = idx_ok_q;
    cur_lo_d  = cur_lo_q;
    cur_hi_d  = cur_hi_q;
    r_lo_d    = r_lo_q;
    r_hi_d    = r_hi_q;
    res_lo_d  = res_lo_q;
    res_hi_d  = res_hi_q;
    res_st_d  = res_st_q;
    mval_d    = mval_q && !m_axis_tready_i;
    mdata_d   = mdata_q;
    muser_d   = muser_q;
    ram_we    = 1'b0;
    ram_waddr = w_q[AW-1:0];
    ram_wdata = {cur_hi_q, cur_lo_q};
    ram_raddr = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          res_lo_d = '0;
          res_hi_d = '0;
          res_st_d = ST_OK;
          r_lo_d   = in_lo;
          r_hi_d   = in_hi;
          i_d      = '0;
          w_d      = '0;
          rpend_d  = 1'b1;
          curv_d   = 1'b0;
          touch_d  = 1'b0;
          idx_ok_d = (32'(in_idx) < 32'(count_q)) && (32'(in_idx) < MAX_RANGES);
          // Reads fetch the requested entry; scans start at entry zero.
          if (in_func == FUNC_READ) begin
            ram_raddr = AW'(in_idx);
          end
          case (in_func)
            FUNC_INSERT: begin
              if (in_lo > in_hi) begin
                res_st_d = ST_BAD_RANGE;
              end
            end
            FUNC_CLEAR: count_d = '0;
            default: ;
          endcase
        end
      end
      S_READ: begin
        if (idx_ok_q) begin
          res_lo_d = e_lo;
          res_hi_d = e_hi;
        end else begin
          res_st_d = ST_BAD_INDEX;
        end
      end
      S_FULLCHK: begin
        if (scan_end) begin
          i_d = '0;
          if (!touch_q) begin
            res_st_d = ST_FULL;
          end
        end else begin
          touch_d = touch_q || touches;
          i_d     = i_q + CW'(1);
          if (i_q + CW'(1) != count_q) begin
            ram_raddr = AW'(i_q + CW'(1));
          end
        end
      end
      S_MERGE: begin
        if (!rpend_q && scan_end) begin
          // Flush the last accumulated interval and settle the count.
          ram_we  = 1'b1;
          count_d = w_q + CW'(1);
        end else begin
          if (joins) begin
            if (x_hi > cur_hi_q) begin
              cur_hi_d = x_hi;
            end
          end else begin
            ram_we   = curv_q;
            w_d      = w_q + CW'(curv_q);
            cur_lo_d = x_lo;
            cur_hi_d = x_hi;
            curv_d   = 1'b1;
          end
          if (take_r) begin
            rpend_d = 1'b0;
            if (!scan_end) begin
              ram_raddr = i_q[AW-1:0];
            end
          end else begin
            i_d = i_q + CW'(1);
            if (i_q + CW'(1) != count_q) begin
              ram_raddr = AW'(i_q + CW'(1));
            end
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          mval_d  = 1'b1;
          mdata_d = {TotalW'(count_q), res_hi_q, res_lo_q};
          muser_d = res_st_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      mval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      mval_q  <= mval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q      <= i_d;
    w_q      <= w_d;
    rpend_q  <= rpend_d;
    curv_q   <= curv_d;
    touch_q  <= touch_d;
    idx_ok_q <= idx_ok_d;
    cur_lo_q <= cur_lo_d;
    cur_hi_q <= cur_hi_d;
    r_lo_q   <= r_lo_d;
    r_hi_q   <= r_hi_d;
    res_lo_q <= res_lo_d;
    res_hi_q <= res_hi_d;
    res_st_q <= res_st_d;
    mdata_q  <= mdata_d;
    muser_q  <= muser_d;
  end

  // The table never holds more entries than it has room for.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= MAX_RANGES)
    else $error("entry count above table depth");

  // Write-back never overtakes the read pointer, so no unread entry is lost.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MERGE) |-> (w_q <= i_q))
    else $error("write pointer ahead of read pointer");

  // The RAM is written only during the merge pass.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_MERGE))
    else $error("table write outside merge pass");

  // A full-table insert with no merge partner leaves the count unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FULLCHK && scan_end && !touch_q) |=> $stable(count_q))
    else $error("refused insert changed the table");

endmodule

// ===== design/sism_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sism_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
